// ===== sv/arctrk_pkg.sv =====
// Arcball rotation tracker: shared types, constants, sequencing tables and
// rounding helpers. No dependencies.
package arctrk_pkg;

   localparam int CoordBits = 12;
   localparam int FracBits  = 14;
   localparam int AccBits   = 40;
   localparam int DivBits   = 38;
   localparam int DenBits   = 29;
   localparam int RadBits   = 36;
   localparam int RootBits  = 18;
   localparam int ReqBits   = 88;
   localparam int UserBits  = 2;
   localparam int RspBits   = 72;
   localparam int CsrBits   = 16;
   localparam int CsrAddrBits = 3;

   typedef logic signed [15:0]        q14_type;
   typedef logic signed [16:0]        quat_type;
   typedef logic signed [AccBits-1:0] acc_type;

   typedef enum logic [1:0] {
      CMD_BEGIN = 2'd0,
      CMD_DRAG  = 2'd1,
      CMD_END   = 2'd2,
      CMD_SET   = 2'd3
   } cmd_type;

   typedef enum logic [CsrAddrBits-1:0] {
      REG_FRAME_W  = 3'd0,
      REG_FRAME_H  = 3'd1,
      REG_OFFSET_X = 3'd2,
      REG_OFFSET_Y = 3'd3,
      REG_RADIUS   = 3'd4
   } reg_type;

   typedef enum logic [12:0] {
      S_IDLE  = 13'b0000000000001,
      S_BALL  = 13'b0000000000010,
      S_HALVE = 13'b0000000000100,
      S_MAG   = 13'b0000000001000,
      S_BROOT = 13'b0000000010000,
      S_RIM   = 13'b0000000100000,
      S_POINT = 13'b0000001000000,
      S_QUAT  = 13'b0000010000000,
      S_NSQ   = 13'b0000100000000,
      S_NROOT = 13'b0001000000000,
      S_QDIV  = 13'b0010000000000,
      S_PROD  = 13'b0100000000000,
      S_EMIT  = 13'b1000000000000
   } state_type;

   localparam q14_type  RotOne  = 16'sd16384;
   localparam quat_type QuatOne = 17'sd16384;
   localparam q14_type  QMax    = 16'sh7fff;
   localparam q14_type  QMin    = 16'sh8000;
   localparam logic [DivBits-1:0] BallLim = DivBits'(2) << FracBits;
   localparam acc_type  OneSq   = acc_type'(1) <<< (2 * FracBits);

   // Drag quaternion terms: q0 = a.b, q1..q3 = cross(b, a)
   localparam logic [1:0] QuatA [16] = '{2'd0, 2'd1, 2'd2, 2'd2, 2'd1, 2'd0, 2'd2, 2'd1,
                                         2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0};
   localparam logic [1:0] QuatB [16] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2, 2'd0, 2'd0,
                                         2'd1, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0};
   localparam logic [15:0] QuatSub   = 16'b0000_0001_0101_0000;
   localparam logic [15:0] QuatFirst = 16'b0000_0000_1010_1001;
   localparam int QuatSteps = 9;

   // Hamilton product start_rotation * q, four terms per component
   localparam logic [1:0] ProdS [16] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3,
                                         2'd0, 2'd2, 2'd3, 2'd1, 2'd0, 2'd3, 2'd1, 2'd2};
   localparam logic [1:0] ProdQ [16] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd0, 2'd3, 2'd2,
                                         2'd2, 2'd0, 2'd1, 2'd3, 2'd3, 2'd0, 2'd2, 2'd1};
   localparam logic [15:0] ProdSub = 16'b1000_1000_1000_1110;

   // Drop FracBits fraction bits, nearest, halves away from zero
   function automatic acc_type round_frac(input acc_type v);
      acc_type mag;
      acc_type r;
      mag = v[AccBits-1] ? -v : v;
      r   = (mag + (acc_type'(1) <<< (FracBits - 1))) >>> FracBits;
      return v[AccBits-1] ? -r : r;
   endfunction

   // Clip to the signed 16 bit range
   function automatic q14_type sat_q14(input acc_type v);
      q14_type r;
      if (v > acc_type'(QMax)) begin
         r = QMax;
      end else if (v < acc_type'(QMin)) begin
         r = QMin;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

// ===== sv/arcball_rotation_tracker.sv =====
// Arcball rotation tracker: pointer events in, current rotation out.
// Depends on arctrk_pkg (types, sequencing tables, rounding helpers).
//
// One word in, one word out per event. End drag, set rotation and a drag-to
// outside a drag go straight to the emit state. Begin drag and drag-to take
// longer (drag-to less when the drag quaternion has zero length): the time is
// set by the bit-serial restoring divider (two quotients for the ball point,
// two more for rim projection, four for the normalization) and by the
// bit-serial square root (once or twice), plus a halving pass and the steps
// on the shared 18x18 multiplier. A new event is taken while the previous
// result still waits in the output register. Registers are to be written
// through csr_* only while the block is idle; the block itself does not
// enforce this. A zero frame size or radius acts as one.
module arcball_rotation_tracker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // pointer_x[11:0], pointer_y[23:12], set_w[39:24], set_x[55:40],
   // set_y[71:56], set_z[87:72]
   input  logic [arctrk_pkg::ReqBits-1:0]     req_tdata,
   // cmd[1:0]
   input  logic [arctrk_pkg::UserBits-1:0]    req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // rot_w[15:0], rot_x[31:16], rot_y[47:32], rot_z[63:48], drag_active[64]
   output logic [arctrk_pkg::RspBits-1:0]     rsp_tdata,
   input  logic                               csr_we,
   input  logic [arctrk_pkg::CsrAddrBits-1:0] csr_addr,
   input  logic [arctrk_pkg::CsrBits-1:0]     csr_wdata
);
   import arctrk_pkg::*;

   // control state
   state_type     state_ff, state_in;
   logic [4:0]    step_ff, step_in;
   logic          drag_ff, drag_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          div_busy_ff, div_busy_in;
   logic          sq_busy_ff, sq_busy_in;
   logic [5:0]    div_cnt_ff, div_cnt_in;
   logic [4:0]    sq_cnt_ff, sq_cnt_in;

   // configuration
   logic [12:0]        frame_w_ff, frame_w_in, frame_h_ff, frame_h_in;
   logic signed [12:0] off_x_ff, off_x_in, off_y_ff, off_y_in;
   logic [15:0]        radius_ff, radius_in;

   // architectural state
   q14_type rot_ff [4];
   q14_type rot_in [4];
   q14_type srot_ff [4];
   q14_type srot_in [4];
   q14_type spt_ff [3];
   q14_type spt_in [3];

   // working payload
   cmd_type                cmd_ff, cmd_in;
   logic [CoordBits-1:0]   ptx_ff, ptx_in, pty_ff, pty_in;
   q14_type                bpt_ff [3];
   q14_type                bpt_in [3];
   logic [DivBits-1:0]     vx_ff, vx_in, vy_ff, vy_in;
   logic                   sx_ff, sx_in, sy_ff, sy_in;
   logic                   rim_ff, rim_in;
   logic                   qsign_ff, qsign_in;
   logic [RootBits-1:0]    norm_ff, norm_in;
   quat_type               q_ff [4];
   quat_type               q_in [4];
   acc_type                acc_ff, acc_in;
   logic [RspBits-1:0]     rsp_data_ff, rsp_data_in;

   // divider and square root datapath
   logic [DivBits-1:0]   div_num_ff, div_num_in;
   logic [DenBits-1:0]   div_rem_ff, div_rem_in, div_den_ff, div_den_in;
   logic [RadBits-1:0]   sq_rad_ff, sq_rad_in;
   logic [19:0]          sq_rem_ff, sq_rem_in;
   logic [RootBits-1:0]  sq_root_ff, sq_root_in;

   // combinational helpers
   logic                 req_fire;
   logic                 div_go, sq_go;
   logic [DivBits-1:0]   div_num_go;
   logic [DenBits-1:0]   div_den_go;
   logic [RadBits-1:0]   sq_rad_go;
   logic signed [17:0]   mul_a, mul_b;
   logic signed [35:0]   prod;
   acc_type              term;
   logic [1:0]           q_idx;
   quat_type             q_rd;
   logic [15:0]          q_mag;
   logic [12:0]          fw_eff, fh_eff;
   logic [15:0]          rad_eff;
   logic signed [16:0]   nx, ny;
   logic [15:0]          nx_mag, ny_mag;
   logic [29:0]          div_rem2, div_diff;
   logic                 div_ge;
   logic [21:0]          sq_rem2, sq_trial, sq_diff;
   logic                 sq_ge;
   logic signed [16:0]   vx_s, vy_s, quo_s;
   logic [3:0]           tix;
   logic [1:0]           wb_idx;

   assign req_fire   = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // zero registers act as one
   assign fw_eff  = (frame_w_ff == 13'd0) ? 13'd1 : frame_w_ff;
   assign fh_eff  = (frame_h_ff == 13'd0) ? 13'd1 : frame_h_ff;
   assign rad_eff = (radius_ff == 16'd0) ? 16'd1 : radius_ff;

   // pointer relative to ball center, doubled to stay integral
   assign nx = $signed({4'b0, ptx_ff, 1'b0}) - $signed({{3{off_x_ff[12]}}, off_x_ff, 1'b0})
             - $signed({4'b0, fw_eff});
   assign ny = $signed({4'b0, fh_eff}) - $signed({4'b0, pty_ff, 1'b0})
             - $signed({{3{off_y_ff[12]}}, off_y_ff, 1'b0});
   assign nx_mag = nx[16] ? 16'(-nx) : nx[15:0];
   assign ny_mag = ny[16] ? 16'(-ny) : ny[15:0];

   assign vx_s  = sx_ff ? -$signed({1'b0, vx_ff[15:0]}) : $signed({1'b0, vx_ff[15:0]});
   assign vy_s  = sy_ff ? -$signed({1'b0, vy_ff[15:0]}) : $signed({1'b0, vy_ff[15:0]});
   assign quo_s = $signed({1'b0, div_num_ff[15:0]});

   assign tix  = step_ff[3:0];
   assign q_rd = q_ff[q_idx];
   assign q_mag = q_rd[16] ? 16'(-q_rd) : q_rd[15:0];

   // shared multiplier
   assign prod = mul_a * mul_b;

   // one restoring divide step
   assign div_rem2 = {div_rem_ff, div_num_ff[DivBits-1]};
   assign div_diff = div_rem2 - {1'b0, div_den_ff};
   assign div_ge   = (div_rem2 >= {1'b0, div_den_ff});

   // one square root digit
   assign sq_rem2  = {sq_rem_ff, sq_rad_ff[RadBits-1 -: 2]};
   assign sq_trial = {2'b0, sq_root_ff, 2'b01};
   assign sq_diff  = sq_rem2 - sq_trial;
   assign sq_ge    = (sq_rem2 >= sq_trial);

   // sequencer and next-state logic
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      drag_in      = drag_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      frame_w_in   = frame_w_ff;
      frame_h_in   = frame_h_ff;
      off_x_in     = off_x_ff;
      off_y_in     = off_y_ff;
      radius_in    = radius_ff;
      rot_in       = rot_ff;
      srot_in      = srot_ff;
      spt_in       = spt_ff;
      cmd_in       = cmd_ff;
      ptx_in       = ptx_ff;
      pty_in       = pty_ff;
      bpt_in       = bpt_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      rim_in       = rim_ff;
      qsign_in     = qsign_ff;
      norm_in      = norm_ff;
      q_in         = q_ff;
      acc_in       = acc_ff;
      div_go       = 1'b0;
      div_num_go   = '0;
      div_den_go   = '0;
      sq_go        = 1'b0;
      sq_rad_go    = '0;
      mul_a        = '0;
      mul_b        = '0;
      term         = '0;
      q_idx        = step_ff[1:0];
      wb_idx       = '0;

      // register writes
      if (csr_we) begin
         case (csr_addr)
            REG_FRAME_W:  frame_w_in = csr_wdata[12:0];
            REG_FRAME_H:  frame_h_in = csr_wdata[12:0];
            REG_OFFSET_X: off_x_in   = $signed(csr_wdata[12:0]);
            REG_OFFSET_Y: off_y_in   = $signed(csr_wdata[12:0]);
            REG_RADIUS:   radius_in  = csr_wdata;
            default:      ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd_in  = cmd_type'(req_tuser);
               ptx_in  = req_tdata[11:0];
               pty_in  = req_tdata[23:12];
               step_in = '0;
               case (cmd_type'(req_tuser))
                  CMD_BEGIN: state_in = S_BALL;
                  CMD_DRAG:  state_in = drag_ff ? S_BALL : S_EMIT;
                  CMD_END: begin
                     drag_in  = 1'b0;
                     state_in = S_EMIT;
                  end
                  CMD_SET: begin
                     drag_in   = 1'b0;
                     rot_in[0] = req_tdata[39:24];
                     rot_in[1] = req_tdata[55:40];
                     rot_in[2] = req_tdata[71:56];
                     rot_in[3] = req_tdata[87:72];
                     state_in  = S_EMIT;
                  end
                  default: state_in = S_EMIT;
               endcase
            end
         end

         // x and y onto the ball: round(n * 2^22 / (radius * frame))
         S_BALL: begin
            mul_a = 18'($signed({1'b0, rad_eff}));
            mul_b = (step_ff == 5'd0) ? 18'($signed({1'b0, fw_eff}))
                                      : 18'($signed({1'b0, fh_eff}));
            if (step_ff == 5'd0) begin
               div_go     = 1'b1;
               div_den_go = prod[DenBits-1:0];
               div_num_go = {nx_mag, 22'b0} + {10'b0, prod[DenBits-1:1]};
               sx_in      = nx[16];
               step_in    = 5'd1;
            end else if (!div_busy_ff) begin
               if (step_ff == 5'd1) begin
                  vx_in      = div_num_ff;
                  div_go     = 1'b1;
                  div_den_go = prod[DenBits-1:0];
                  div_num_go = {ny_mag, 22'b0} + {10'b0, prod[DenBits-1:1]};
                  sy_in      = ny[16];
                  step_in    = 5'd2;
               end else begin
                  vy_in    = div_num_ff;
                  state_in = S_HALVE;
               end
            end
         end

         // halve both magnitudes until neither exceeds 2.0
         S_HALVE: begin
            if (vx_ff > BallLim || vy_ff > BallLim) begin
               vx_in = vx_ff >> 1;
               vy_in = vy_ff >> 1;
            end else begin
               state_in = S_MAG;
               step_in  = '0;
            end
         end

         // x^2 + y^2, then root of it or of its distance to one
         S_MAG: begin
            if (step_ff == 5'd0) begin
               mul_a   = $signed({2'b0, vx_ff[15:0]});
               mul_b   = $signed({2'b0, vx_ff[15:0]});
               acc_in  = acc_type'(prod);
               step_in = 5'd1;
            end else if (step_ff == 5'd1) begin
               mul_a   = $signed({2'b0, vy_ff[15:0]});
               mul_b   = $signed({2'b0, vy_ff[15:0]});
               acc_in  = acc_ff + acc_type'(prod);
               step_in = 5'd2;
            end else begin
               rim_in    = (acc_ff > OneSq);
               sq_go     = 1'b1;
               sq_rad_go = (acc_ff > OneSq) ? acc_ff[RadBits-1:0]
                                            : RadBits'(OneSq - acc_ff);
               state_in  = S_BROOT;
            end
         end

         S_BROOT: begin
            if (!sq_busy_ff) begin
               if (rim_ff) begin
                  norm_in  = sq_root_ff;
                  state_in = S_RIM;
                  step_in  = '0;
               end else begin
                  bpt_in[0] = vx_s[15:0];
                  bpt_in[1] = vy_s[15:0];
                  bpt_in[2] = sq_root_ff[15:0];
                  state_in  = S_POINT;
               end
            end
         end

         // project onto the rim: round(v * one / |v|)
         S_RIM: begin
            if (step_ff == 5'd0) begin
               div_go     = 1'b1;
               div_den_go = {11'b0, norm_ff};
               div_num_go = {8'b0, vx_ff[15:0], 14'b0} + {21'b0, norm_ff[RootBits-1:1]};
               step_in    = 5'd1;
            end else if (!div_busy_ff) begin
               if (step_ff == 5'd1) begin
                  bpt_in[0]  = sx_ff ? 16'(-quo_s) : quo_s[15:0];
                  div_go     = 1'b1;
                  div_den_go = {11'b0, norm_ff};
                  div_num_go = {8'b0, vy_ff[15:0], 14'b0} + {21'b0, norm_ff[RootBits-1:1]};
                  step_in    = 5'd2;
               end else begin
                  bpt_in[1] = sy_ff ? 16'(-quo_s) : quo_s[15:0];
                  bpt_in[2] = '0;
                  state_in  = S_POINT;
               end
            end
         end

         S_POINT: begin
            if (cmd_ff == CMD_BEGIN) begin
               spt_in   = bpt_ff;
               srot_in  = rot_ff;
               drag_in  = 1'b1;
               state_in = S_EMIT;
            end else begin
               state_in = S_QUAT;
               step_in  = '0;
            end
         end

         // dot and cross terms; round the finished component one step later
         S_QUAT: begin
            if (step_ff < 5'(QuatSteps)) begin
               mul_a  = 18'(spt_ff[QuatA[tix]]);
               mul_b  = 18'(bpt_ff[QuatB[tix]]);
               term   = QuatSub[tix] ? -acc_type'(prod) : acc_type'(prod);
               acc_in = (QuatFirst[tix] ? acc_type'(0) : acc_ff) + term;
            end
            if (step_ff != 5'd0 && (step_ff == 5'(QuatSteps) || QuatFirst[tix])) begin
               wb_idx       = 2'((step_ff - 5'd3) >> 1);
               q_in[wb_idx] = quat_type'(round_frac(acc_ff));
            end
            if (step_ff == 5'(QuatSteps)) begin
               state_in = S_NSQ;
               step_in  = '0;
            end else begin
               step_in = step_ff + 5'd1;
            end
         end

         // squared length of the drag quaternion
         S_NSQ: begin
            if (step_ff < 5'd4) begin
               mul_a   = 18'(q_rd);
               mul_b   = 18'(q_rd);
               acc_in  = ((step_ff == 5'd0) ? acc_type'(0) : acc_ff) + acc_type'(prod);
               step_in = step_ff + 5'd1;
            end else begin
               sq_go     = 1'b1;
               sq_rad_go = acc_ff[RadBits-1:0];
               state_in  = S_NROOT;
            end
         end

         S_NROOT: begin
            if (!sq_busy_ff) begin
               step_in = '0;
               if (sq_root_ff == '0) begin
                  q_in[0]  = QuatOne;
                  q_in[1]  = '0;
                  q_in[2]  = '0;
                  q_in[3]  = '0;
                  state_in = S_PROD;
               end else begin
                  norm_in  = sq_root_ff;
                  state_in = S_QDIV;
               end
            end
         end

         // normalize: round(q * one / n), one component per quotient
         S_QDIV: begin
            if (step_ff == 5'd0 || !div_busy_ff) begin
               if (step_ff != 5'd0) begin
                  wb_idx       = 2'(step_ff - 5'd1);
                  q_in[wb_idx] = qsign_ff ? -quo_s : quo_s;
               end
               if (step_ff < 5'd4) begin
                  qsign_in   = q_rd[16];
                  div_go     = 1'b1;
                  div_den_go = {11'b0, norm_ff};
                  div_num_go = {8'b0, q_mag, 14'b0} + {21'b0, norm_ff[RootBits-1:1]};
                  step_in    = step_ff + 5'd1;
               end else begin
                  state_in = S_PROD;
                  step_in  = '0;
               end
            end
         end

         // rotation = start rotation * q, rounded and clipped
         S_PROD: begin
            if (step_ff < 5'd16) begin
               q_idx  = ProdQ[tix];
               mul_a  = 18'(srot_ff[ProdS[tix]]);
               mul_b  = 18'(q_rd);
               term   = ProdSub[tix] ? -acc_type'(prod) : acc_type'(prod);
               acc_in = ((step_ff[1:0] == 2'd0) ? acc_type'(0) : acc_ff) + term;
            end
            if (step_ff != 5'd0 && step_ff[1:0] == 2'd0) begin
               wb_idx         = 2'((step_ff >> 2) - 5'd1);
               rot_in[wb_idx] = sat_q14(round_frac(acc_ff));
            end
            if (step_ff == 5'd16) begin
               state_in = S_EMIT;
            end else begin
               step_in = step_ff + 5'd1;
            end
         end

         // load the output register once it is free
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {7'b0, drag_ff, rot_ff[3], rot_ff[2], rot_ff[1], rot_ff[0]};
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase

      // divider: one quotient bit per cycle
      div_busy_in = div_busy_ff;
      div_cnt_in  = div_cnt_ff;
      div_num_in  = div_num_ff;
      div_rem_in  = div_rem_ff;
      div_den_in  = div_den_ff;
      if (div_go) begin
         div_busy_in = 1'b1;
         div_cnt_in  = 6'(DivBits);
         div_num_in  = div_num_go;
         div_rem_in  = '0;
         div_den_in  = div_den_go;
      end else if (div_busy_ff) begin
         div_rem_in  = div_ge ? div_diff[DenBits-1:0] : div_rem2[DenBits-1:0];
         div_num_in  = {div_num_ff[DivBits-2:0], div_ge};
         div_cnt_in  = div_cnt_ff - 6'd1;
         div_busy_in = (div_cnt_ff != 6'd1);
      end

      // square root: one root bit per cycle
      sq_busy_in = sq_busy_ff;
      sq_cnt_in  = sq_cnt_ff;
      sq_rad_in  = sq_rad_ff;
      sq_rem_in  = sq_rem_ff;
      sq_root_in = sq_root_ff;
      if (sq_go) begin
         sq_busy_in = 1'b1;
         sq_cnt_in  = 5'(RootBits);
         sq_rad_in  = sq_rad_go;
         sq_rem_in  = '0;
         sq_root_in = '0;
      end else if (sq_busy_ff) begin
         sq_rem_in  = sq_ge ? sq_diff[19:0] : sq_rem2[19:0];
         sq_root_in = {sq_root_ff[RootBits-2:0], sq_ge};
         sq_rad_in  = {sq_rad_ff[RadBits-3:0], 2'b00};
         sq_cnt_in  = sq_cnt_ff - 5'd1;
         sq_busy_in = (sq_cnt_ff != 5'd1);
      end
   end

   // control and architectural registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         drag_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         div_busy_ff  <= 1'b0;
         sq_busy_ff   <= 1'b0;
         div_cnt_ff   <= '0;
         sq_cnt_ff    <= '0;
         frame_w_ff   <= 13'd1;
         frame_h_ff   <= 13'd1;
         off_x_ff     <= '0;
         off_y_ff     <= '0;
         radius_ff    <= 16'd256;
         rot_ff[0]    <= RotOne;
         rot_ff[1]    <= '0;
         rot_ff[2]    <= '0;
         rot_ff[3]    <= '0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         drag_ff      <= drag_in;
         rsp_valid_ff <= rsp_valid_in;
         div_busy_ff  <= div_busy_in;
         sq_busy_ff   <= sq_busy_in;
         div_cnt_ff   <= div_cnt_in;
         sq_cnt_ff    <= sq_cnt_in;
         frame_w_ff   <= frame_w_in;
         frame_h_ff   <= frame_h_in;
         off_x_ff     <= off_x_in;
         off_y_ff     <= off_y_in;
         radius_ff    <= radius_in;
         rot_ff       <= rot_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      srot_ff     <= srot_in;
      spt_ff      <= spt_in;
      cmd_ff      <= cmd_in;
      ptx_ff      <= ptx_in;
      pty_ff      <= pty_in;
      bpt_ff      <= bpt_in;
      vx_ff       <= vx_in;
      vy_ff       <= vy_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      rim_ff      <= rim_in;
      qsign_ff    <= qsign_in;
      norm_ff     <= norm_in;
      q_ff        <= q_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
      div_num_ff  <= div_num_in;
      div_rem_ff  <= div_rem_in;
      div_den_ff  <= div_den_in;
      sq_rad_ff   <= sq_rad_in;
      sq_rem_ff   <= sq_rem_in;
      sq_root_ff  <= sq_root_in;
   end

   // the divider and the root unit never run together
   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(div_busy_ff && sq_busy_ff))
      else $error("divider and square root busy together");

   // an idle sequencer leaves no unit running
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (!div_busy_ff && !sq_busy_ff))
      else $error("arithmetic unit busy while idle");

   // a result appears only from the emit state
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_EMIT))
      else $error("result word raised outside emit");

   // the drag flag moves only on an accepted word or a finished ball point
   a_drag_source: assert property (@(posedge clock) disable iff (reset)
      !$stable(drag_ff) |-> ($past(req_fire) || $past(state_ff == S_POINT)))
      else $error("drag flag changed without cause");

endmodule

// ===== tb/arctrk_checker.sv =====
// Arcball rotation tracker checker: watches the request, response and CSR ports,
// predicts each response word and compares it. Depends on arctrk_pkg.
`timescale 1ns / 100ps
module arctrk_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [arctrk_pkg::ReqBits-1:0]     req_tdata,
   input  logic [arctrk_pkg::UserBits-1:0]    req_tuser,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [arctrk_pkg::RspBits-1:0]     rsp_tdata,
   input  logic                               csr_we,
   input  logic [arctrk_pkg::CsrAddrBits-1:0] csr_addr,
   input  logic [arctrk_pkg::CsrBits-1:0]     csr_wdata,
   output int                                 fail_count,
   output int                                 pending
);
   import arctrk_pkg::*;

   localparam longint unsigned One = 64'd1 << FracBits;

   typedef struct {
      q14_type rot [4];
      bit      drag;
   } pose_word_type;

   pose_word_type pose_q [$];

   // shadow registers and tracker state
   logic [12:0]        frame_w, frame_h;
   logic signed [12:0] off_x, off_y;
   logic [15:0]        radius;
   longint             cur_rot [4];
   longint             start_rot [4];
   longint             start_pt [3];
   bit                 dragging;

   // round(v * m / d), halves away from zero
   function automatic longint rdiv(longint v, longint unsigned m, longint unsigned d);
      longint unsigned mag;
      longint unsigned q;
      mag = (v < 0) ? longint'(-v) : v;
      q = (mag * m + d / 2) / d;
      if (q > 64'h3fff_ffff_ffff_ffff) q = 64'h3fff_ffff_ffff_ffff;
      return (v < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint unsigned absv(longint v);
      return (v < 0) ? longint'(-v) : v;
   endfunction

   // map a pointer position onto the ball
   function automatic void ball_map(input logic [11:0] px, input logic [11:0] py,
                                    output longint p0, output longint p1, output longint p2);
      longint unsigned w, h, r, ax, ay, mag, s;
      longint nx, ny, x, y;
      w = (frame_w == 0) ? 1 : frame_w;
      h = (frame_h == 0) ? 1 : frame_h;
      r = (radius == 0) ? 1 : radius;
      nx = 2 * longint'(px) - 2 * longint'(off_x) - longint'(w);
      ny = longint'(h) - 2 * longint'(py) - 2 * longint'(off_y);
      x = rdiv(nx, 64'd256 << FracBits, r * w);
      y = rdiv(ny, 64'd256 << FracBits, r * h);
      ax = absv(x);
      ay = absv(y);
      // pull far points back toward the ball, keeping direction
      while (ax > 2 * One || ay > 2 * One) begin
         ax = ax >> 1;
         ay = ay >> 1;
      end
      x = (x < 0) ? -longint'(ax) : longint'(ax);
      y = (y < 0) ? -longint'(ay) : longint'(ay);
      mag = ax * ax + ay * ay;
      if (mag > One * One) begin
         s = floor_sqrt(mag);
         p0 = rdiv(x, One, s);
         p1 = rdiv(y, One, s);
         p2 = 0;
      end else begin
         p0 = x;
         p1 = y;
         p2 = longint'(floor_sqrt(One * One - mag));
      end
   endfunction

   function automatic longint clip_q14(longint v);
      longint t;
      t = rdiv(v, 1, One);
      if (t > 32767) t = 32767;
      if (t < -32768) t = -32768;
      return t;
   endfunction

   // apply one event to the tracker state
   function automatic void track_event(input cmd_type cmd, input logic [87:0] d);
      longint a [3];
      longint b [3];
      longint q [4];
      longint s [4];
      longint unsigned n2, n;
      case (cmd)
         CMD_BEGIN: begin
            start_rot = cur_rot;
            ball_map(d[11:0], d[23:12], a[0], a[1], a[2]);
            start_pt = a;
            dragging = 1;
         end
         CMD_DRAG: begin
            if (dragging) begin
               a = start_pt;
               s = start_rot;
               ball_map(d[11:0], d[23:12], b[0], b[1], b[2]);
               q[0] = rdiv(a[0] * b[0] + a[1] * b[1] + a[2] * b[2], 1, One);
               q[1] = rdiv(b[1] * a[2] - b[2] * a[1], 1, One);
               q[2] = rdiv(b[2] * a[0] - b[0] * a[2], 1, One);
               q[3] = rdiv(b[0] * a[1] - b[1] * a[0], 1, One);
               n2 = 0;
               for (int i = 0; i < 4; i++) n2 += absv(q[i]) * absv(q[i]);
               n = floor_sqrt(n2);
               if (n == 0) begin
                  q[0] = One;
                  q[1] = 0;
                  q[2] = 0;
                  q[3] = 0;
               end else begin
                  for (int i = 0; i < 4; i++) q[i] = rdiv(q[i], One, n);
               end
               cur_rot[0] = clip_q14(s[0] * q[0] - s[1] * q[1] - s[2] * q[2] - s[3] * q[3]);
               cur_rot[1] = clip_q14(s[0] * q[1] + s[1] * q[0] + s[2] * q[3] - s[3] * q[2]);
               cur_rot[2] = clip_q14(s[0] * q[2] + s[2] * q[0] + s[3] * q[1] - s[1] * q[3]);
               cur_rot[3] = clip_q14(s[0] * q[3] + s[3] * q[0] + s[1] * q[2] - s[2] * q[1]);
            end
         end
         CMD_END: dragging = 0;
         default: begin
            dragging = 0;
            for (int i = 0; i < 4; i++) cur_rot[i] = longint'($signed(d[24 + 16 * i +: 16]));
         end
      endcase
   endfunction

   task automatic report(input string what, input longint got, input longint want);
      $display("%0t: mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   // watch the ports; all sampled values are the ones before the edge
   always @(posedge clock) begin
      pose_word_type pw;
      pose_word_type want;
      if (reset) begin
         frame_w   = 1;
         frame_h   = 1;
         off_x     = 0;
         off_y     = 0;
         radius    = 256;
         cur_rot   = '{16384, 0, 0, 0};
         start_rot = '{0, 0, 0, 0};
         start_pt  = '{0, 0, 0};
         dragging  = 0;
         pose_q.delete();
      end else begin
         if (csr_we) begin
            case (reg_type'(csr_addr))
               REG_FRAME_W:  frame_w = csr_wdata[12:0];
               REG_FRAME_H:  frame_h = csr_wdata[12:0];
               REG_OFFSET_X: off_x   = csr_wdata[12:0];
               REG_OFFSET_Y: off_y   = csr_wdata[12:0];
               REG_RADIUS:   radius  = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            track_event(cmd_type'(req_tuser), req_tdata);
            for (int i = 0; i < 4; i++) pw.rot[i] = q14_type'(cur_rot[i]);
            pw.drag = dragging;
            pose_q.push_back(pw);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pose_q.size() == 0) begin
               $display("%0t: response word with nothing expected", $realtime);
               fail_count++;
            end else begin
               want = pose_q.pop_front();
               for (int i = 0; i < 4; i++)
                  if ($signed(rsp_tdata[16 * i +: 16]) !== want.rot[i])
                     report($sformatf("rot[%0d]", i),
                            longint'($signed(rsp_tdata[16 * i +: 16])),
                            longint'(want.rot[i]));
               if (rsp_tdata[64] !== want.drag)
                  report("drag_active", longint'(rsp_tdata[64]), longint'(want.drag));
            end
         end
      end
      pending = pose_q.size();
   end

   initial begin
      fail_count = 0;
      pending    = 0;
   end

endmodule

// ===== tb/tb_arcball_rotation_tracker.sv =====
// Arcball rotation tracker testbench top: clock, reset, stimulus and verdict.
// Depends on arctrk_pkg, arcball_rotation_tracker and arctrk_checker.
`timescale 1ns / 100ps
module tb_arcball_rotation_tracker;
   import arctrk_pkg::*;

   localparam int CycleLimit = 3000000;

   logic                   clock = 0;
   logic                   reset = 1;
   logic                   req_tvalid = 0;
   logic                   req_tready;
   logic [ReqBits-1:0]     req_tdata = '0;
   logic [UserBits-1:0]    req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 0;
   logic [RspBits-1:0]     rsp_tdata;
   logic                   csr_we = 0;
   logic [CsrAddrBits-1:0] csr_addr = '0;
   logic [CsrBits-1:0]     csr_wdata = '0;
   int                     fail_count;
   int                     pending;
   int                     tx_idle_pct = 6;
   int                     rx_idle_pct = 61;
   int                     words_sent = 0;
   int                     cycles = 0;

   arcball_rotation_tracker u_dut (.*);

   arctrk_checker u_check (.*);

   always #5 clock = ~clock;

   // receiver stalls
   always @(posedge clock) rsp_tready <= ($urandom_range(99) >= rx_idle_pct);

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // send one word, with a random gap before it
   task automatic send_word(input cmd_type cmd, input logic [11:0] px, input logic [11:0] py,
                            input logic [63:0] quat);
      int gap;
      gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(1, 5) : 0;
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= cmd;
      req_tdata  <= {quat, py, px};
      do @(posedge clock); while (!req_tready);
      words_sent++;
      // shift idling pattern by progress
      if (words_sent == 500) begin
         tx_idle_pct = 61;
         rx_idle_pct = 6;
      end else if (words_sent == 1000) begin
         tx_idle_pct = 0;
         rx_idle_pct = 0;
      end
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      wait (pending == 0);
      repeat (6) @(posedge clock);
   endtask

   task automatic csr_write(input reg_type idx, input logic [15:0] val);
      csr_we    <= 1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 0;
   endtask

   task automatic load_geometry(input int w, input int h, input int ox, input int oy,
                                input int r);
      drain();
      csr_write(REG_FRAME_W, 16'(w));
      csr_write(REG_FRAME_H, 16'(h));
      csr_write(REG_OFFSET_X, 16'(ox));
      csr_write(REG_OFFSET_Y, 16'(oy));
      csr_write(REG_RADIUS, 16'(r));
      @(posedge clock);
   endtask

   function automatic logic [63:0] rand_quat();
      logic [63:0] q;
      q = {$urandom, $urandom};
      // mostly values near the unit range
      if ($urandom_range(3) != 0)
         for (int i = 0; i < 4; i++) q[16 * i +: 16] = 16'($signed($urandom_range(32768)) - 16384);
      return q;
   endfunction

   task automatic random_words(input int n);
      int count;
      int k;
      count = 0;
      while (count < n) begin
         k = $urandom_range(99);
         if (k < 75) begin
            // well-formed drag with random content
            send_word(CMD_BEGIN, 12'($urandom), 12'($urandom), {$urandom, $urandom});
            k = $urandom_range(1, 8);
            repeat (k) send_word(CMD_DRAG, 12'($urandom), 12'($urandom), {$urandom, $urandom});
            count += k + 1;
            if ($urandom_range(4) != 0) begin
               send_word(CMD_END, 12'($urandom), 12'($urandom), {$urandom, $urandom});
               count++;
            end
         end else if (k < 88) begin
            send_word(CMD_SET, 12'($urandom), 12'($urandom), rand_quat());
            count++;
         end else begin
            send_word(cmd_type'($urandom_range(3)), 12'($urandom), 12'($urandom),
                      {$urandom, $urandom});
            count++;
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // reset register values: tiny frame, every point far outside
      send_word(CMD_DRAG, 12'd5, 12'd5, 64'd0);
      send_word(CMD_END, 12'd0, 12'd0, 64'd0);
      send_word(CMD_BEGIN, 12'd0, 12'd0, 64'd0);
      send_word(CMD_DRAG, 12'hfff, 12'hfff, 64'd0);

      // square frame: center, rim, corners, degenerate drag, restarts
      load_geometry(512, 512, 0, 0, 256);
      send_word(CMD_SET, 12'd0, 12'd0, {16'sd0, 16'sd0, 16'sd0, 16'sd16384});
      send_word(CMD_BEGIN, 12'd256, 12'd256, 64'd0);
      send_word(CMD_DRAG, 12'd256, 12'd256, 64'd0);
      send_word(CMD_DRAG, 12'd512, 12'd256, 64'd0);
      send_word(CMD_DRAG, 12'd0, 12'd0, 64'd0);
      send_word(CMD_DRAG, 12'hfff, 12'hfff, 64'd0);
      send_word(CMD_BEGIN, 12'd300, 12'd100, 64'd0);
      send_word(CMD_DRAG, 12'd200, 12'd400, 64'd0);
      send_word(CMD_END, 12'd0, 12'd0, 64'd0);
      send_word(CMD_END, 12'd0, 12'd0, 64'd0);
      send_word(CMD_DRAG, 12'd10, 12'd10, 64'd0);
      send_word(CMD_SET, 12'd0, 12'd0, {16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000});
      send_word(CMD_BEGIN, 12'd100, 12'd300, 64'd0);
      send_word(CMD_DRAG, 12'd400, 12'd50, 64'd0);
      send_word(CMD_SET, 12'd0, 12'd0, {16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff});
      send_word(CMD_BEGIN, 12'd0, 12'hfff, 64'd0);
      send_word(CMD_DRAG, 12'hfff, 12'd0, 64'd0);

      // random phases over several register settings
      load_geometry(640, 480, 0, 0, 256);
      random_words(180);
      // hold off until every response is back, then resume
      drain();
      random_words(180);
      load_geometry(4096, 1, -4096, 4095, 65535);
      random_words(270);
      load_geometry(0, 8191, 4095, -4096, 0);
      random_words(270);
      load_geometry(100, 4096, 37, -20, 1);
      random_words(270);
      load_geometry(1024, 768, -100, 60, 384);
      random_words(270);

      drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/arctrk_pkg.sv
sv/arcball_rotation_tracker.sv
tb/arctrk_checker.sv
tb/tb_arcball_rotation_tracker.sv
